// ===== design/bit_crusher_dither_null_test_top_defines.svh =====
// ----------------------------------------------------------------------------
// bit crusher assertion macros
// shared concurrent assertion helpers for the bit crusher design files
// ----------------------------------------------------------------------------
`ifndef BIT_CRUSHER_DITHER_NULL_TEST_TOP_DEFINES_SVH
`define BIT_CRUSHER_DITHER_NULL_TEST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bit crusher package
// shared constants, types and the quantizer step table
// ----------------------------------------------------------------------------
`default_nettype none
package bcd_pkg;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int SILENCE_RUN_DEF    = 512;
  localparam int RESIDUAL_SHIFT_DEF = 8;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] LCG_A_RESET = 32'd12764;
  localparam logic [31:0] LCG_B_RESET = 32'd209375;

  localparam logic [1:0] REG_LISTEN = 2'd0;
  localparam logic [1:0] REG_BITS   = 2'd1;
  localparam logic [1:0] REG_RATE   = 2'd2;
  localparam logic [1:0] REG_JITTER = 2'd3;

  // datapath operations, one per controller state
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_PHASE   = 4'd1;
  localparam logic [3:0] OP_LCGA    = 4'd2;
  localparam logic [3:0] OP_THRESH  = 4'd3;
  localparam logic [3:0] OP_DITHER  = 4'd4;
  localparam logic [3:0] OP_ACC     = 4'd5;
  localparam logic [3:0] OP_PROD    = 4'd6;
  localparam logic [3:0] OP_PROD_HI = 4'd7;
  localparam logic [3:0] OP_OUT     = 4'd8;

  typedef struct packed {
    logic [3:0] op;
  } bcd_cmd_t;

  typedef struct packed {
    logic capture;
  } bcd_status_t;

  // step = round(2^40 / levels), levels = max(1, 2^bits - 1)
  function automatic logic [40:0] step_lookup(input logic [4:0] bits);
    logic [40:0] s;
    case (bits)
      5'd0, 5'd1: s = 41'h100_0000_0000;
      5'd2:  s = 41'd366503875925;
      5'd3:  s = 41'd157073089682;
      5'd4:  s = 41'd73300775185;
      5'd5:  s = 41'd35468117025;
      5'd6:  s = 41'd17452565520;
      5'd7:  s = 41'd8657571872;
      5'd8:  s = 41'd4311810305;
      5'd9:  s = 41'd2151686160;
      5'd10: s = 41'd1074791425;
      5'd11: s = 41'd537133184;
      5'd12: s = 41'd268501008;
      5'd13: s = 41'd134234114;
      5'd14: s = 41'd67112960;
      5'd15: s = 41'd33555456;
      5'd16: s = 41'd16777472;
      5'd17: s = 41'd8388672;
      5'd18: s = 41'd4194320;
      5'd19: s = 41'd2097156;
      5'd20: s = 41'd1048577;
      5'd21: s = 41'd524288;
      5'd22: s = 41'd262144;
      5'd23: s = 41'd131072;
      default: s = 41'd65536;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

// ===== design/bcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bit crusher controller
// sequences one word through the datapath steps
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_crusher_dither_null_test_top_defines.svh"
module bcd_ctrl
  import bcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_fire,
  input  wire logic        out_busy,
  input  wire bcd_status_t status,
  output bcd_cmd_t         cmd,
  output logic             idle
);
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LCGA    = 3'd1;
  localparam logic [2:0] S_THRESH  = 3'd2;
  localparam logic [2:0] S_DITHER  = 3'd3;
  localparam logic [2:0] S_ACC     = 3'd4;
  localparam logic [2:0] S_PROD    = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;
  localparam logic [2:0] S_PROD_HI = 3'd7;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_PHASE; state_next = S_LCGA;
      end
      S_LCGA: begin
        if (status.capture) begin
          cmd.op = OP_LCGA; state_next = S_THRESH;
        end else state_next = S_DITHER;
      end
      S_THRESH:  begin cmd.op = OP_THRESH;  state_next = S_DITHER; end
      S_DITHER:  begin cmd.op = OP_DITHER;  state_next = S_ACC; end
      S_ACC:     begin cmd.op = OP_ACC;     state_next = S_PROD; end
      S_PROD:    begin cmd.op = OP_PROD;    state_next = S_PROD_HI; end
      S_PROD_HI: begin cmd.op = OP_PROD_HI; state_next = S_OUT; end
      S_OUT: if (!out_busy) begin
        cmd.op = OP_OUT; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `BC_ASSERT_NEXT(a_start_leaves_idle, clk, rst, in_fire && idle, state == S_LCGA)
  `BC_ASSERT_IMPL(a_out_not_busy, clk, rst, cmd.op == OP_OUT, !out_busy)
  `BC_ASSERT_NEXT(a_thresh_after_lcg, clk, rst, cmd.op == OP_LCGA, state == S_THRESH)
endmodule
`default_nettype wire

// ===== design/bcd_datapath.sv =====
// ----------------------------------------------------------------------------
// bit crusher datapath
// hold, jitter, dither, quantizer and output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_crusher_dither_null_test_top_defines.svh"
module bcd_datapath
  import bcd_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int SILENCE_RUN    = SILENCE_RUN_DEF,
  parameter int RESIDUAL_SHIFT = RESIDUAL_SHIFT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bcd_cmd_t                      cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic                          listen_mode,
  input  wire logic [4:0]                    crush_bits,
  input  wire logic [8:0]                    hold_rate,
  input  wire logic [15:0]                   jitter_span,
  input  wire logic                          out_ready,
  output bcd_status_t                        status,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      out_data
);
  localparam int RUNW = $clog2(SILENCE_RUN + 1);
  localparam int SF   = 41 - SAMPLE_BITS;
  localparam int PW   = 41 + 32 + 2;

  logic signed [SAMPLE_BITS-1:0] x, held;
  logic [8:0]  phase;
  logic [16:0] thresh;
  logic [31:0] lcg_a, lcg_b;
  logic [RUNW-1:0] zrun;
  logic        capture;
  logic signed [33:0] dither;
  logic signed [31:0] q;
  logic signed [PW-1:0] prod;
  logic [4:0]  bits;
  logic [24:0] lv;
  logic [8:0]  rate;

  logic [8:0] phase_inc;
  logic signed [32:0] offc;
  logic signed [49:0] off;
  logic signed [18:0] t;
  logic [RUNW-1:0] zrun_n;
  logic signed [SAMPLE_BITS+26:0] scaled;
  logic signed [SAMPLE_BITS+60:0] acc;
  logic signed [PW-1:0] p_full;
  logic signed [PW+RESIDUAL_SHIFT:0] res;
  logic signed [SAMPLE_BITS-1:0] sat_v;
  logic [40:0] step;
  logic [21:0] step_part;
  logic signed [53:0] pp;

  assign bits = (crush_bits > 5'd24) ? 5'd24 : crush_bits;
  assign lv   = (bits < 5'd2) ? 25'd1 : ((25'd1 << bits) - 25'd1);
  assign rate = (hold_rate == 9'd0) ? 9'd1
              : (hold_rate > 9'd256) ? 9'd256 : hold_rate;
  assign phase_inc = phase + 9'd1;
  assign status.capture = capture;
  assign step = step_lookup(bits);

  always_comb begin
    offc = $signed({1'b0, lcg_a}) - 33'sh0_8000_0000;
    off  = offc * $signed({1'b0, jitter_span});
    t    = $signed({2'b0, rate, 8'd0}) + 19'(off >>> 32);
    zrun_n = zrun;
    if (held == '0) begin
      if (zrun < RUNW'(SILENCE_RUN)) zrun_n = zrun + 1'b1;
    end else zrun_n = '0;
    scaled = held * $signed({1'b0, lv});
    acc = (64'(scaled) <<< (33 - SAMPLE_BITS)) + 64'(dither) + 64'sh8000_0000;
    // step multiply in two parts: low 21 bits of the step, then the high 20
    step_part = (cmd.op == OP_PROD) ? {1'b0, step[20:0]} : {2'b0, step[40:21]};
    pp = q * $signed(step_part);
    p_full = (prod + (PW'(1) <<< (SF - 1))) >>> SF;
    if (listen_mode)
      res = (($signed({p_full[PW-1], p_full}) - (PW+1)'(x)) <<< RESIDUAL_SHIFT);
    else
      res = (PW+RESIDUAL_SHIFT+1)'(p_full);
    if (res > $signed((PW+RESIDUAL_SHIFT+1)'((64'd1 << (SAMPLE_BITS-1)) - 1)))
      sat_v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else if (res < -$signed((PW+RESIDUAL_SHIFT+1)'(64'd1 << (SAMPLE_BITS-1))))
      sat_v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else sat_v = res[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0; phase <= '0; thresh <= 17'd256;
      lcg_a <= LCG_A_RESET; lcg_b <= LCG_B_RESET; zrun <= '0;
      capture <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd.op != OP_OUT) out_valid <= 1'b0;
      case (cmd.op)
        OP_PHASE: begin
          x <= sample_in;
          if ({phase_inc, 8'd0} >= thresh) begin
            held <= sample_in; phase <= '0; capture <= 1'b1;
          end else begin
            phase <= phase_inc; capture <= 1'b0;
          end
        end
        OP_LCGA:   lcg_a <= lcg_a * LCG_MUL + LCG_ADD;
        OP_THRESH: thresh <= (t < 19'sd256) ? 17'd256 : t[16:0];
        OP_DITHER: begin
          zrun <= zrun_n;
          if (zrun_n < RUNW'(SILENCE_RUN)) begin
            lcg_a <= lcg_a * LCG_MUL + LCG_ADD;
            lcg_b <= lcg_b * LCG_MUL + LCG_ADD;
            dither <= $signed({2'b0, lcg_a * LCG_MUL + LCG_ADD})
                    + $signed({2'b0, lcg_b * LCG_MUL + LCG_ADD}) - 34'sh1_0000_0000;
          end else dither <= '0;
        end
        OP_ACC:     q <= 32'(acc >>> 32);
        OP_PROD:    prod <= PW'(pp);
        OP_PROD_HI: prod <= prod + (PW'(pp) <<< 21);
        OP_OUT: begin out_data <= sat_v; out_valid <= 1'b1; end
        default: ;
      endcase
    end
  end

  `BC_ASSERT_IMPL(a_zrun_cap, clk, rst, 1'b1, zrun <= RUNW'(SILENCE_RUN))
  `BC_ASSERT_IMPL(a_thresh_floor, clk, rst, 1'b1, thresh >= 17'd256)
  `BC_ASSERT_NEXT(a_phase_clear, clk, rst, cmd.op == OP_PHASE && {phase_inc, 8'd0} >= thresh,
    phase == '0)
endmodule
`default_nettype wire

// ===== design/bit_crusher_dither_null_test_top.sv =====
// ----------------------------------------------------------------------------
// bit crusher with dither and null test
// sample-and-hold decimation, tpdf dither, quantizer and residual listen mode
// ----------------------------------------------------------------------------
// One word in gives one word out. After accept the controller walks the datapath
// one step per cycle unless the output is busy (capture check, with the lcg step
// on a capture and then the threshold step, dither, accumulate, step multiply low
// half, high half, saturate). A new word is not taken before the previous one has
// left the controller; it is taken while the controller is back in idle, even while
// the previous result still waits in the output register; a result that is still
// waiting when the next one is ready holds the controller until it is taken.
`default_nettype none
module bit_crusher_dither_null_test_top
  import bcd_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int SILENCE_RUN    = SILENCE_RUN_DEF,
  parameter int RESIDUAL_SHIFT = RESIDUAL_SHIFT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [SAMPLE_BITS-1:0] s_tdata,   // sample_in
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [SAMPLE_BITS-1:0]      m_tdata,   // sample_out
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  logic        listen_mode;
  logic [4:0]  crush_bits;
  logic [8:0]  hold_rate;
  logic [15:0] jitter_span;
  bcd_cmd_t    cmd;
  bcd_status_t status;
  logic        idle, in_fire;
  logic signed [SAMPLE_BITS-1:0] out_data;

  assign pready = 1'b1;

  // register file, word aligned
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_mode <= 1'b0; crush_bits <= '0; hold_rate <= 9'd1; jitter_span <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LISTEN: listen_mode <= pwdata[0];
        REG_BITS:   crush_bits  <= pwdata[4:0];
        REG_RATE:   hold_rate   <= pwdata[8:0];
        REG_JITTER: jitter_span <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LISTEN: prdata = {31'd0, listen_mode};
      REG_BITS:   prdata = {27'd0, crush_bits};
      REG_RATE:   prdata = {23'd0, hold_rate};
      REG_JITTER: prdata = {16'd0, jitter_span};
      default:    prdata = '0;
    endcase
  end

  assign s_tready = idle;
  assign in_fire  = s_tvalid && s_tready;

  bcd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_tvalid && !m_tready),
    .status(status), .cmd(cmd), .idle(idle)
  );

  bcd_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS), .SILENCE_RUN(SILENCE_RUN), .RESIDUAL_SHIFT(RESIDUAL_SHIFT)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sample_in(s_tdata),
    .listen_mode(listen_mode), .crush_bits(crush_bits), .hold_rate(hold_rate),
    .jitter_span(jitter_span), .out_ready(m_tready), .status(status),
    .out_valid(m_tvalid), .out_data(out_data)
  );

  assign m_tdata = out_data;
endmodule
`default_nettype wire
